@@ rtl/matrix_vector_multiply_defines.svh @@
// Assertion macros shared by the matrix-vector multiply RTL.
// Included by the top level; depends on nothing else.
`ifndef MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MVM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mvm_pkg.sv @@
// Types and constants of the matrix-vector multiply block.
// Used by the channel interfaces and every module; depends on nothing.
package mvm_pkg;

  typedef logic        [9:0]  mvm_index_t;
  typedef logic signed [31:0] mvm_value_t;
  typedef logic signed [63:0] mvm_sum_t;
  typedef logic        [15:0] mvm_row_num_t;
  typedef logic        [10:0] mvm_cols_cfg_t;
  typedef logic        [16:0] mvm_rows_cfg_t;
  typedef logic        [31:0] mvm_cfg_data_t;

  typedef enum logic {
    REG_COLS_IN_USE = 1'b0,
    REG_ROWS_IN_USE = 1'b1
  } mvm_cfg_reg_e;

  localparam logic MODE_VECTOR = 1'b0;
  localparam logic MODE_MATRIX = 1'b1;

  localparam mvm_cols_cfg_t COLS_RESET = 11'd1024;
  localparam mvm_rows_cfg_t ROWS_RESET = 17'd65536;

  // Travels with each matrix item down the pipeline.
  typedef struct packed {
    logic         end_row;
    logic         last_row;
    mvm_row_num_t row_number;
  } mvm_tag_t;

endpackage

@@ rtl/mvm_if.sv @@
// Valid/ready channel interfaces of the matrix-vector multiply block.
// Depends on mvm_pkg.
interface mvm_in_if;
  import mvm_pkg::*;
  logic       valid;
  logic       ready;
  logic       mode;
  mvm_index_t entry_index;
  mvm_value_t value;
  modport source(output valid, mode, entry_index, value, input ready);
  modport sink(input valid, mode, entry_index, value, output ready);
endinterface

interface mvm_out_if;
  import mvm_pkg::*;
  logic         valid;
  logic         ready;
  mvm_row_num_t row_number;
  mvm_sum_t     row_sum;
  logic         last_row;
  modport source(output valid, row_number, row_sum, last_row, input ready);
  modport sink(input valid, row_number, row_sum, last_row, output ready);
endinterface

interface mvm_cfg_if;
  import mvm_pkg::*;
  logic          valid;
  logic          ready;
  mvm_cfg_reg_e  index;
  mvm_cfg_data_t data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/matrix_vector_multiply.sv @@
// Matrix-vector multiply, top level.
// Depends on mvm_pkg, the channel interfaces, mvm_seq, mvm_vstore and mvm_mac.
//
// Usage: write the vector first through in_i with mode 0, one entry per item at
// entry_index. Then stream the matrix row-major with mode 1; each element is
// multiplied by the vector entry at its column and added to a saturating Q32.32
// sum. The item that completes a row makes one result on out_o carrying the
// row number, the row sum and a flag for the final row. After the final row the
// row count starts again, so another matrix may follow with the same vector.
// cfg_i sets the column and row counts; write it only while the block is idle.
//
// Throughput is one item per cycle. A result reaches the output register after
// the item that ends its row is taken and passes vector read, multiply, then
// accumulate. When out_o is stalled, elements that do not end a row still
// flow into the sum; in_i drops ready only once a row end is held behind the
// waiting result. Reset clears the counts to their defaults and the sum and
// positions to zero; the vector store is not cleared and must be written first.
`include "matrix_vector_multiply_defines.svh"

module matrix_vector_multiply #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mvm_in_if.sink     in_i,
  mvm_out_if.source  out_o,
  mvm_cfg_if.sink    cfg_i
);
  import mvm_pkg::*;

  localparam int CPW = $clog2(MAX_COLS);

  logic           accept, mat_step, vec_write, mac_ready;
  logic [CPW-1:0] col_pos;
  logic [CPW+9:0] waddr_ext;
  mvm_tag_t       tag;
  mvm_value_t     vec_data;

  assign in_i.ready = mac_ready;
  assign accept     = in_i.valid && mac_ready;
  assign mat_step   = accept && (in_i.mode == MODE_MATRIX);
  // Writes beyond the store are dropped.
  assign vec_write  = accept && (in_i.mode == MODE_VECTOR)
                      && (32'(in_i.entry_index) < 32'(MAX_COLS));
  assign waddr_ext  = {{CPW{1'b0}}, in_i.entry_index};

  mvm_seq #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .step_i   (mat_step),
    .col_pos_o(col_pos),
    .tag_o    (tag)
  );

  mvm_vstore #(
    .MAX_COLS(MAX_COLS)
  ) u_vstore (
    .clk_i  (clk_i),
    .we_i   (vec_write),
    .waddr_i(waddr_ext[CPW-1:0]),
    .wdata_i(in_i.value),
    .re_i   (mat_step),
    .raddr_i(col_pos),
    .rdata_o(vec_data)
  );

  mvm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (mat_step),
    .value_i(in_i.value),
    .tag_i  (tag),
    .vec_i  (vec_data),
    .ready_o(mac_ready),
    .out_o  (out_o)
  );

  // Input backpressure can only come from a result waiting at the output.
  `MVM_ASSERT_SAME(a_stall_needs_result, clk_i, rst_ni, !in_i.ready, out_o.valid, "input stalled without a waiting result")
  `MVM_ASSERT_NEXT(a_row_end_resets_col, clk_i, rst_ni, mat_step && tag.end_row, col_pos == '0, "column position not cleared at row end")
  `MVM_ASSERT_NEXT(a_col_advances, clk_i, rst_ni, mat_step && !tag.end_row, col_pos == $past(col_pos) + CPW'(1), "column position did not advance")

endmodule

@@ rtl/mvm_vstore.sv @@
// Vector store: one-port synchronous memory with a registered read.
// Depends on mvm_pkg.
module mvm_vstore #(
  parameter  int MAX_COLS = 1024,
  localparam int AW       = $clog2(MAX_COLS)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  mvm_pkg::mvm_value_t wdata_i,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr_i,
  output mvm_pkg::mvm_value_t rdata_o
);
  import mvm_pkg::*;

  mvm_value_t mem [MAX_COLS];
  mvm_value_t rdata_q;

  // Reads and writes belong to different items, so they never share a cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mvm_seq.sv @@
// Configuration registers and column/row position counters.
// Depends on mvm_pkg and mvm_cfg_if.
module mvm_seq #(
  parameter  int MAX_COLS = 1024,
  parameter  int MAX_ROWS = 65536,
  localparam int CPW      = $clog2(MAX_COLS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mvm_cfg_if.sink           cfg_i,
  input  logic              step_i,
  output logic [CPW-1:0]    col_pos_o,
  output mvm_pkg::mvm_tag_t tag_o
);
  import mvm_pkg::*;

  localparam int RPW = $clog2(MAX_ROWS);
  localparam int CCW = ($clog2(MAX_COLS + 1) > 11) ? $clog2(MAX_COLS + 1) : 11;
  localparam int RCW = ($clog2(MAX_ROWS + 1) > 17) ? $clog2(MAX_ROWS + 1) : 17;

  mvm_cols_cfg_t  cols_q;
  mvm_rows_cfg_t  rows_q;
  logic [CPW-1:0] col_pos_q, col_pos_d;
  logic [RPW-1:0] row_pos_q, row_pos_d;
  logic [CCW-1:0] cols_eff;
  logic [RCW-1:0] rows_eff;
  logic [RPW+15:0] row_ext;
  logic           end_row;
  logic           last_row;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_COLS_IN_USE: cols_q <= cfg_i.data[10:0];
        REG_ROWS_IN_USE: rows_q <= cfg_i.data[16:0];
        default: ;
      endcase
    end
  end

  // Counts of zero act as one; counts above the maximum act as the maximum.
  always_comb begin
    if (cols_q == '0) begin
      cols_eff = CCW'(1);
    end else if (CCW'(cols_q) > CCW'(MAX_COLS)) begin
      cols_eff = CCW'(MAX_COLS);
    end else begin
      cols_eff = CCW'(cols_q);
    end
    if (rows_q == '0) begin
      rows_eff = RCW'(1);
    end else if (RCW'(rows_q) > RCW'(MAX_ROWS)) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(rows_q);
    end
  end

  // A lowered count ends the row or matrix as soon as the position passes it.
  assign end_row  = (CCW'(col_pos_q) + CCW'(1)) >= cols_eff;
  assign last_row = (RCW'(row_pos_q) + RCW'(1)) >= rows_eff;
  assign row_ext  = {16'b0, row_pos_q};

  always_comb begin
    col_pos_d = col_pos_q;
    row_pos_d = row_pos_q;
    if (step_i) begin
      if (end_row) begin
        col_pos_d = '0;
        row_pos_d = last_row ? '0 : row_pos_q + RPW'(1);
      end else begin
        col_pos_d = col_pos_q + CPW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
    end else begin
      col_pos_q <= col_pos_d;
      row_pos_q <= row_pos_d;
    end
  end

  assign col_pos_o        = col_pos_q;
  assign tag_o.end_row    = end_row;
  assign tag_o.last_row   = last_row;
  assign tag_o.row_number = row_ext[15:0];

endmodule

@@ rtl/mvm_mac.sv @@
// Multiply stage, saturating accumulator and output register.
// Depends on mvm_pkg and mvm_out_if.
module mvm_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  mvm_pkg::mvm_value_t value_i,
  input  mvm_pkg::mvm_tag_t   tag_i,
  input  mvm_pkg::mvm_value_t vec_i,
  output logic                ready_o,
  mvm_out_if.source           out_o
);
  import mvm_pkg::*;

  function automatic mvm_sum_t sat_add(mvm_sum_t a, mvm_sum_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add = s[63:0];
    end
  endfunction

  logic       s1_v_q, s2_v_q, out_v_q;
  mvm_tag_t   s1_tag_q, s2_tag_q;
  mvm_value_t s1_val_q;
  mvm_sum_t   prod_q;
  mvm_sum_t   sum_q, sum_sat;
  mvm_tag_t   out_tag_q;
  mvm_sum_t   out_sum_q;
  logic       out_free, s2_take, s2_ready, s1_ready;

  // An item that does not end a row accumulates even while a result waits.
  assign out_free = !out_v_q || out_o.ready;
  assign s2_take  = s2_v_q && (!s2_tag_q.end_row || out_free);
  assign s2_ready = !s2_v_q || s2_take;
  assign s1_ready = !s1_v_q || s2_ready;
  assign ready_o  = s1_ready;
  assign sum_sat  = sat_add(sum_q, prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      sum_q   <= '0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= step_i;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (s2_take) begin
        sum_q <= s2_tag_q.end_row ? '0 : sum_sat;
      end
      if (s2_take && s2_tag_q.end_row) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && step_i) begin
      s1_tag_q <= tag_i;
      s1_val_q <= value_i;
    end
    if (s2_ready && s1_v_q) begin
      s2_tag_q <= s1_tag_q;
      prod_q   <= 64'(s1_val_q) * 64'(vec_i);
    end
    if (s2_take && s2_tag_q.end_row) begin
      out_tag_q <= s2_tag_q;
      out_sum_q <= sum_sat;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.row_number = out_tag_q.row_number;
  assign out_o.row_sum    = out_sum_q;
  assign out_o.last_row   = out_tag_q.last_row;

endmodule

@@ tb/matrix_vector_multiply_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for matrix_vector_multiply: vector writes and matrix elements
// stream in, a predictor works out every row sum, and each result is checked in order.
// Depends on mvm_pkg, the channel interfaces in mvm_if.sv and the block's RTL.
module matrix_vector_multiply_test;
  import mvm_pkg::*;

  localparam int COLS_MAX = 1024;
  localparam int ROWS_MAX = 65536;
  localparam int SETTLE_CYCLES = 8;
  localparam mvm_value_t VAL_MIN = 32'sh8000_0000;
  localparam mvm_value_t VAL_MAX = 32'sh7fff_ffff;
  localparam mvm_sum_t SUM_MIN = 64'sh8000_0000_0000_0000;
  localparam mvm_sum_t SUM_MAX = 64'sh7fff_ffff_ffff_ffff;

  typedef struct {
    logic       mode;
    mvm_index_t entry_index;
    mvm_value_t value;
  } operand_t;

  typedef struct {
    mvm_row_num_t row_number;
    mvm_sum_t     row_sum;
    logic         last_row;
  } row_total_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mvm_in_if  in_if ();
  mvm_out_if out_if ();
  mvm_cfg_if cfg_if ();

  matrix_vector_multiply u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  operand_t   operands_pending[$];
  row_total_t row_totals_due[$];
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;
  logic       in_taken = 1'b0;
  int         errors = 0;
  int         items_taken = 0;
  int         rows_checked = 0;
  int         saturated_rows = 0;
  int         reg_writes = 0;

  // Shadow of the block: vector store, accumulator, positions and counts.
  mvm_value_t    vec_mem[COLS_MAX];
  mvm_sum_t      dot_acc;
  int unsigned   col_at;
  int unsigned   row_at;
  mvm_cols_cfg_t cols_reg;
  mvm_rows_cfg_t rows_reg;

  always #5 clk_i = ~clk_i;

  function automatic void predict_row_sum(operand_t op);
    int unsigned ncols;
    int unsigned nrows;
    mvm_sum_t    elem;
    mvm_sum_t    entry;
    mvm_sum_t    prod;
    logic [64:0] wide;
    row_total_t  done;
    if (op.mode == MODE_VECTOR) begin
      vec_mem[op.entry_index] = op.value;
      return;
    end
    ncols = (cols_reg == 0) ? 1 : (cols_reg > COLS_MAX) ? COLS_MAX : cols_reg;
    nrows = (rows_reg == 0) ? 1 : (rows_reg > ROWS_MAX) ? ROWS_MAX : rows_reg;
    elem = op.value;
    entry = vec_mem[col_at];
    prod = elem * entry;
    // One extra bit shows a signed overflow; the sum is then clamped to the limit.
    wide = {dot_acc[63], dot_acc} + {prod[63], prod};
    if (wide[64] != wide[63]) begin
      dot_acc = wide[64] ? SUM_MIN : SUM_MAX;
    end else begin
      dot_acc = wide[63:0];
    end
    if (col_at + 1 < ncols) begin
      col_at++;
      return;
    end
    done.row_number = row_at[15:0];
    done.row_sum = dot_acc;
    done.last_row = (row_at + 1 >= nrows);
    row_totals_due.push_back(done);
    if (dot_acc == SUM_MIN || dot_acc == SUM_MAX) begin
      saturated_rows++;
    end
    dot_acc = '0;
    col_at = 0;
    row_at = done.last_row ? 0 : row_at + 1;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("%0t: row result mismatch on %s: got %0h, expected %0h", $time, field, got, want);
  endtask

  function automatic mvm_value_t rand_value();
    case ($urandom_range(5))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return $urandom_range(131071) - 65536;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_vec(mvm_index_t idx, mvm_value_t val);
    operand_t op;
    op.mode = MODE_VECTOR;
    op.entry_index = idx;
    op.value = val;
    operands_pending.push_back(op);
  endtask

  task automatic push_elem(mvm_value_t val);
    operand_t op;
    op.mode = MODE_MATRIX;
    op.entry_index = mvm_index_t'($urandom());
    op.value = val;
    operands_pending.push_back(op);
  endtask

  // Waits until every queued item is in and every row sum is out, then lets the
  // pipeline drain items that make no result.
  task automatic wait_idle();
    while (operands_pending.size() != 0 || in_if.valid || row_totals_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(mvm_cfg_reg_e idx, int unsigned setting);
    mvm_cfg_data_t mask;
    mvm_cfg_data_t data;
    mask = (idx == REG_COLS_IN_USE) ? 32'h0000_07ff : 32'h0001_ffff;
    // Bits above the register width are don't-care, so they get random values.
    data = ($urandom() & ~mask) | (setting & mask);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == REG_COLS_IN_USE) begin
      cols_reg = data[10:0];
    end else begin
      rows_reg = data[16:0];
    end
    reg_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  always @(posedge clk_i) begin : monitor
    operand_t   got_op;
    row_total_t want;
    if (rst_ni) begin
      in_taken = in_if.valid && in_if.ready;
      if (in_taken) begin
        got_op.mode = in_if.mode;
        got_op.entry_index = in_if.entry_index;
        got_op.value = in_if.value;
        predict_row_sum(got_op);
        items_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        if (row_totals_due.size() == 0) begin
          report_mismatch("row_number with nothing expected", 64'(out_if.row_number), '0);
        end else begin
          want = row_totals_due.pop_front();
          rows_checked++;
          if (out_if.row_number !== want.row_number) begin
            report_mismatch("row_number", 64'(out_if.row_number), 64'(want.row_number));
          end
          if (out_if.row_sum !== want.row_sum) begin
            report_mismatch("row_sum", out_if.row_sum, want.row_sum);
          end
          if (out_if.last_row !== want.last_row) begin
            report_mismatch("last_row", 64'(out_if.last_row), 64'(want.last_row));
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin : driver
    operand_t op;
    if (rst_ni) begin
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      if (!in_if.valid || in_taken) begin
        if (operands_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          op = operands_pending.pop_front();
          in_if.valid <= 1'b1;
          in_if.mode <= op.mode;
          in_if.entry_index <= op.entry_index;
          in_if.value <= op.value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_cols[6] = '{3, 1, 7, 0, 16, 1025};
    int unsigned phase_rows[6] = '{5, 2, 131071, 1, 4, 2};
    int          phase_src[6] = '{0, 84, 0, 26, 26, 0};
    int          phase_sink[6] = '{0, 0, 84, 26, 26, 0};
    int          phase_len[6] = '{120, 100, 120, 100, 120, 200};
    int          filled;
    int unsigned eff;
    in_if.valid = 1'b0;
    in_if.mode = MODE_VECTOR;
    in_if.entry_index = '0;
    in_if.value = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_COLS_IN_USE;
    cfg_if.data = '0;
    cols_reg = COLS_RESET;
    rows_reg = ROWS_RESET;
    dot_acc = '0;
    col_at = 0;
    row_at = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Short rows of extreme operands: positive overflow, negative overflow, and
    // a row that keeps adding after it has saturated and ends the matrix.
    write_reg(REG_COLS_IN_USE, 4);
    write_reg(REG_ROWS_IN_USE, 3);
    for (int i = 0; i < 4; i++) begin
      push_vec(mvm_index_t'(i), VAL_MIN);
    end
    filled = 4;
    repeat (4) push_elem(VAL_MIN);
    repeat (4) push_elem(VAL_MAX);
    push_elem(VAL_MIN);
    push_elem(VAL_MIN);
    push_elem(VAL_MAX);
    push_elem('0);
    // Leave a row half done, then shrink the column count under it.
    push_elem(1);
    push_elem(-1);
    wait_idle();
    write_reg(REG_COLS_IN_USE, 2);
    push_elem(32'sh0001_0000);
    // Now at row one; a row count of one makes it the final row at once.
    wait_idle();
    write_reg(REG_ROWS_IN_USE, 1);
    push_elem(5);
    push_elem(7);
    // Zero counts behave as one column and one row.
    wait_idle();
    write_reg(REG_COLS_IN_USE, 0);
    write_reg(REG_ROWS_IN_USE, 0);
    push_elem(3);
    push_elem(-3);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_reg(REG_COLS_IN_USE, phase_cols[p]);
      write_reg(REG_ROWS_IN_USE, phase_rows[p]);
      src_idle_pct = phase_src[p];
      sink_stall_pct = phase_sink[p];
      // Every vector entry this phase can reach must hold a value before any
      // element reads it; no more columns are reached than elements are sent.
      eff = (phase_cols[p] == 0) ? 1 : (phase_cols[p] > COLS_MAX) ? COLS_MAX : phase_cols[p];
      if (eff > col_at + phase_len[p]) begin
        eff = col_at + phase_len[p];
      end
      while (filled < eff) begin
        push_vec(filled[9:0], rand_value());
        filled++;
      end
      for (int k = 0; k < phase_len[p]; k++) begin
        if ($urandom_range(99) < 12) begin
          push_vec(mvm_index_t'($urandom_range(COLS_MAX - 1)), rand_value());
        end else begin
          push_elem(rand_value());
        end
      end
    end

    // The full-width phase leaves a long row open; cut it short with one column.
    wait_idle();
    write_reg(REG_COLS_IN_USE, 1);
    repeat (3) push_elem(rand_value());
    wait_idle();

    $display("Run covered %0d items and %0d register writes over six idle and stall mixes,",
             items_taken, reg_writes);
    $display("with %0d row sums checked, %0d of them saturated.", rows_checked, saturated_rows);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d row sums still outstanding.", row_totals_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mvm_pkg.sv
rtl/mvm_if.sv
rtl/mvm_vstore.sv
rtl/mvm_seq.sv
rtl/mvm_mac.sv
rtl/matrix_vector_multiply.sv
tb/matrix_vector_multiply_test.sv
